// ===== rtl/four_digit_seven_segment_scanner_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the four digit seven segment scanner
// Implication checks, same cycle and next cycle, with synchronous reset
// ---------------------------------------------------------------------------
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define FDSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fdss assertion failed");

`define FDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fdss assertion failed");

`else

`define FDSS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define FDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/fdss_pkg.sv =====
// ---------------------------------------------------------------------------
// fdss_pkg
// Types, codes and glyph table of the four digit seven segment scanner
// ---------------------------------------------------------------------------
package fdss_pkg;

    localparam int VALUE_W = 15;
    localparam int MAG_W   = 14;
    localparam int CODE_W  = 5;
    localparam int PHASE_W = 10;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [2:0] CFG_DOT     = 3'd0;
    localparam logic [2:0] CFG_DISABLE = 3'd1;
    localparam logic [2:0] CFG_FLASH   = 3'd2;
    localparam logic [2:0] CFG_ZEROS   = 3'd3;
    localparam logic [2:0] CFG_ANODE   = 3'd4;

    localparam logic [CODE_W-1:0] CODE_MINUS = 5'd16;
    localparam logic [CODE_W-1:0] CODE_BLANK = 5'd17;

    localparam logic [7:0] DOT_BIT = 8'h80;

    typedef logic [3:0][CODE_W-1:0] t_codes;

    typedef struct packed {
        logic [3:0] dot_mask;
        logic [3:0] disable_mask;
        logic [3:0] flash_mask;
        logic       show_zeros;
        logic       common_anode;
    } t_cfg;

    function automatic logic [7:0] glyph(input logic [CODE_W-1:0] code);
        logic [7:0] seg;
        case (code)
            5'd0:  seg = 8'h3F;
            5'd1:  seg = 8'h06;
            5'd2:  seg = 8'h5B;
            5'd3:  seg = 8'h4F;
            5'd4:  seg = 8'h66;
            5'd5:  seg = 8'h6D;
            5'd6:  seg = 8'h7D;
            5'd7:  seg = 8'h07;
            5'd8:  seg = 8'h7F;
            5'd9:  seg = 8'h6F;
            5'd10: seg = 8'h77;
            5'd11: seg = 8'h7C;
            5'd12: seg = 8'h39;
            5'd13: seg = 8'h5E;
            5'd14: seg = 8'h79;
            5'd15: seg = 8'h71;
            CODE_MINUS: seg = 8'h40;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/four_digit_seven_segment_scanner.sv =====
// ---------------------------------------------------------------------------
// four_digit_seven_segment_scanner
// Multiplexed four digit seven segment driver: value loads and scan ticks
// ---------------------------------------------------------------------------
// channel  handshake               payload
// in       i_in_valid/o_in_ready   i_req_type, i_value
// out      o_out_valid/i_out_ready o_digit_index, o_digit_drive, o_segment_byte,
//                                  o_shown_value
// cfg      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One item per cycle unless a tick waits on a stalled result. An item sits in
// the input register, then an in-range load updates the digit codes and a tick
// fills the result register. A stalled result holds only a pending tick; loads
// and an empty input register keep moving. Synchronous reset, no clearing pass;
// config is taken every cycle.
// ---------------------------------------------------------------------------
`include "four_digit_seven_segment_scanner_defines.svh"

module four_digit_seven_segment_scanner #(
    parameter int FLASH_ON_MS     = 500,
    parameter int FLASH_PERIOD_MS = 1000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic signed [fdss_pkg::VALUE_W-1:0] i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_digit_index,
    output logic [3:0]                          o_digit_drive,
    output logic [7:0]                          o_segment_byte,
    output logic signed [fdss_pkg::VALUE_W-1:0] o_shown_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [2:0]                          i_cfg_index,
    input  logic [3:0]                          i_cfg_data
);
    import fdss_pkg::*;

    t_cfg                       r_cfg;
    logic                       r_in_valid;
    logic                       r_in_type;
    logic signed [VALUE_W-1:0]  r_in_value;
    t_codes                     r_codes;
    logic signed [VALUE_W-1:0]  r_held_value;
    logic [1:0]                 r_scan_pos;
    logic [PHASE_W-1:0]         r_flash_phase;
    logic [PHASE_W-1:0]         n_flash_phase;
    logic                       r_out_valid;
    logic [1:0]                 r_out_index;
    logic [3:0]                 r_out_drive;
    logic [7:0]                 r_out_seg;
    logic signed [VALUE_W-1:0]  r_out_shown;

    logic       advance;
    logic       tick_fire;
    logic       load_fire;
    logic       in_range;
    t_codes     split_codes;
    logic [3:0] drive;
    logic [7:0] segment;
    logic       flash_on;

    assign advance   = !r_in_valid || (r_in_type == REQ_LOAD) || !r_out_valid || i_out_ready;
    assign tick_fire = r_in_valid && advance && (r_in_type == REQ_TICK);
    assign load_fire = r_in_valid && (r_in_type == REQ_LOAD) && in_range;
    assign flash_on  = r_flash_phase < PHASE_W'(FLASH_ON_MS);

    always_comb begin
        n_flash_phase = r_flash_phase + PHASE_W'(1);
        if (n_flash_phase >= PHASE_W'(FLASH_PERIOD_MS)) begin
            n_flash_phase = '0;
        end
    end

    fdss_split u_split (
        .i_value    (r_in_value),
        .i_cfg      (r_cfg),
        .o_in_range (in_range),
        .o_codes    (split_codes)
    );

    fdss_render u_render (
        .i_pos      (r_scan_pos),
        .i_codes    (r_codes),
        .i_cfg      (r_cfg),
        .i_flash_on (flash_on),
        .o_drive    (drive),
        .o_segment  (segment)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= '{dot_mask: 4'h0, disable_mask: 4'h0, flash_mask: 4'h0,
                               show_zeros: 1'b1, common_anode: 1'b0};
            r_in_valid    <= 1'b0;
            r_codes       <= {4{CODE_BLANK}};
            r_held_value  <= '0;
            r_scan_pos    <= '0;
            r_flash_phase <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_DOT:     r_cfg.dot_mask     <= i_cfg_data;
                    CFG_DISABLE: r_cfg.disable_mask <= i_cfg_data;
                    CFG_FLASH:   r_cfg.flash_mask   <= i_cfg_data;
                    CFG_ZEROS:   r_cfg.show_zeros   <= i_cfg_data[0];
                    CFG_ANODE:   r_cfg.common_anode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (advance) begin
                r_in_valid <= i_in_valid;
            end
            if (load_fire) begin
                r_codes      <= split_codes;
                r_held_value <= r_in_value;
            end
            if (tick_fire) begin
                r_scan_pos    <= r_scan_pos + 2'd1;
                r_flash_phase <= n_flash_phase;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_type  <= i_req_type;
            r_in_value <= i_value;
        end
        if (tick_fire) begin
            r_out_index <= r_scan_pos;
            r_out_drive <= drive;
            r_out_seg   <= segment;
            r_out_shown <= r_held_value;
        end
    end

    assign o_in_ready     = advance;
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_out_valid;
    assign o_digit_index  = r_out_index;
    assign o_digit_drive  = r_out_drive;
    assign o_segment_byte = r_out_seg;
    assign o_shown_value  = r_out_shown;

    `FDSS_ASSERT_NEXT(a_scan_step, i_clk, i_rst_n, tick_fire, r_scan_pos == $past(r_scan_pos) + 2'd1)
    `FDSS_ASSERT_IMP(a_phase_range, i_clk, i_rst_n, 1'b1, r_flash_phase < PHASE_W'(FLASH_PERIOD_MS))
    `FDSS_ASSERT_NEXT(a_bad_load, i_clk, i_rst_n, r_in_valid && (r_in_type == REQ_LOAD) && !in_range, $stable(r_held_value) && $stable(r_codes))
    `FDSS_ASSERT_IMP(a_one_enable, i_clk, i_rst_n, r_out_valid, $onehot0(r_out_drive ^ {4{!r_cfg.common_anode}}))

endmodule

// ===== rtl/fdss_split.sv =====
// ---------------------------------------------------------------------------
// fdss_split
// Range check and decimal split of a loaded value, with leading zero blanking
// ---------------------------------------------------------------------------
module fdss_split (
    input  logic signed [fdss_pkg::VALUE_W-1:0] i_value,
    input  fdss_pkg::t_cfg                      i_cfg,
    output logic                                o_in_range,
    output fdss_pkg::t_codes                    o_codes
);
    import fdss_pkg::*;

    logic              neg;
    logic [MAG_W-1:0]  mag;
    logic [27:0]       p1, p2, p3;
    logic [9:0]        q1;
    logic [6:0]        q2;
    logic [3:0]        q3;
    logic [MAG_W-1:0]  d3, d2, d1;

    assign o_in_range = (i_value >= -15'sd999) && (i_value <= 15'sd9999);
    assign neg        = i_value[VALUE_W-1];
    assign mag        = neg ? MAG_W'(-i_value) : MAG_W'(i_value);

    // reciprocal multiplies, exact for 0..9999
    assign p1 = 28'(mag) * 28'd6554;
    assign p2 = 28'(mag) * 28'd5243;
    assign p3 = 28'(mag) * 28'd8389;
    assign q1 = p1[25:16];
    assign q2 = p2[25:19];
    assign q3 = p3[26:23];

    assign d3 = mag - (MAG_W'({q1, 3'b000}) + MAG_W'({q1, 1'b0}));
    assign d2 = MAG_W'(q1) - (MAG_W'({q2, 3'b000}) + MAG_W'({q2, 1'b0}));
    assign d1 = MAG_W'(q2) - (MAG_W'({q3, 3'b000}) + MAG_W'({q3, 1'b0}));

    always_comb begin
        o_codes[0] = {1'b0, q3};
        o_codes[1] = {1'b0, d1[3:0]};
        o_codes[2] = {1'b0, d2[3:0]};
        o_codes[3] = {1'b0, d3[3:0]};
        if (neg) begin
            o_codes[0] = CODE_MINUS;
        end else if (!i_cfg.show_zeros) begin
            if ((mag < 14'd1000) && !i_cfg.dot_mask[0]) begin
                o_codes[0] = CODE_BLANK;
                if ((mag < 14'd100) && !i_cfg.dot_mask[1]) begin
                    o_codes[1] = CODE_BLANK;
                    if ((mag < 14'd10) && !i_cfg.dot_mask[2]) begin
                        o_codes[2] = CODE_BLANK;
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/fdss_render.sv =====
// ---------------------------------------------------------------------------
// fdss_render
// Segment byte and digit enables for the scanned position
// ---------------------------------------------------------------------------
module fdss_render (
    input  logic [1:0]       i_pos,
    input  fdss_pkg::t_codes i_codes,
    input  fdss_pkg::t_cfg   i_cfg,
    input  logic             i_flash_on,
    output logic [3:0]       o_drive,
    output logic [7:0]       o_segment
);
    import fdss_pkg::*;

    logic [3:0] pos_bit;
    logic       dotted;
    logic       lit;
    logic       enabled;
    logic [7:0] seg;

    assign pos_bit = 4'b0001 << i_pos;
    assign dotted  = i_cfg.dot_mask[i_pos];
    assign lit     = !i_cfg.disable_mask[i_pos] && (!i_cfg.flash_mask[i_pos] || i_flash_on);

    always_comb begin
        if (lit) begin
            seg     = glyph(i_codes[i_pos]) ^ (dotted ? DOT_BIT : 8'h00);
            enabled = 1'b1;
        end else if (dotted) begin
            seg     = DOT_BIT;
            enabled = 1'b1;
        end else begin
            seg     = 8'h00;
            enabled = 1'b0;
        end
    end

    assign o_drive   = (i_cfg.common_anode ? 4'h0 : 4'hF) ^ (enabled ? pos_bit : 4'h0);
    assign o_segment = i_cfg.common_anode ? ~seg : seg;

endmodule
